[rtl/lms_pkg.sv]
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants of the multiplexed LED scanner.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int NUM_LEDS_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_OVERHEAD = 1'd1;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_LATCH   = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_ADVANCE = 2'd3;

    localparam logic STATUS_LIT  = 1'b0;
    localparam logic STATUS_DONE = 1'b1;

    localparam logic [7:0]  NO_POSITION   = 8'hFF;
    localparam logic [15:0] DWELL_LIMIT   = 16'd64000;
    localparam logic [15:0] FRAME_WAIT    = 16'd2000;
    localparam logic [9:0]  SCALE_RESET   = 10'd1;
    localparam logic [15:0] OVERHEAD_RST  = 16'd0;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] led_index;
        logic [7:0] brightness;
        logic       wrap_around;
    } t_in_req;

    typedef struct packed {
        logic        status;
        logic [3:0]  lit_index;
        logic [15:0] wait_ticks;
    } t_out_rsp;

endpackage

[rtl/led_multiplex_scanner.sv]
// Write and clear requests are done on acceptance and leave the sequencer idle;
// a latch request sweeps the working store entry by entry; an advance steps
// through the latched entries (one memory read each), then MUL1, MUL2, DWELL, PUSH.
// Requests are taken one at a time, only while the sequencer is idle.
// Results leave through an output register, so a request is taken while one
// waits. Reset clears the per-entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// led_multiplex_scanner
// Brightness stores, latch copy and scan sequencer with dwell calculation.
// ----------------------------------------------------------------------------
module led_multiplex_scanner #(
    parameter int NUM_LEDS = lms_pkg::NUM_LEDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lms_pkg::t_in_req                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lms_pkg::t_out_rsp                o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LATCH = 4'd1;
    localparam logic [3:0] S_STEP  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_DWELL = 4'd6;
    localparam logic [3:0] S_PUSH  = 4'd7;

    logic [7:0] wrk_mem [NUM_LEDS];
    logic [7:0] lat_mem [NUM_LEDS];

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic [NUM_LEDS-1:0] r_w_valid;
    logic [NUM_LEDS-1:0] r_l_valid;
    logic [9:0]          r_scale;
    logic [15:0]         r_ovh;
    logic [7:0]          r_scan;
    logic [7:0]          r_cand;
    logic                r_wrap;
    logic [AW-1:0]       r_cnt;
    logic                r_cp_vld;
    logic [AW-1:0]       r_cp_addr;
    logic                r_cp_wv;
    logic [7:0]          r_wrk_q;
    logic [7:0]          r_lat_q;
    logic                r_lat_v;
    logic [7:0]          r_level;
    logic [15:0]         r_sq;
    logic [25:0]         r_raw;
    lms_pkg::t_out_rsp   r_res;
    logic                r_out_valid;
    lms_pkg::t_out_rsp   r_out;

    logic          accept;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [7:0]    cand_inc;
    logic          beyond;
    logic [7:0]    cand_n;
    logic [AW-1:0] rd_addr;
    logic [25:0]   ovh_ext;
    logic [25:0]   net;
    logic [15:0]   dwell;
    logic          push_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign wr_ok    = ({5'd0, i_in.led_index} < 9'(NUM_LEDS));
    assign wr_addr  = AW'(i_in.led_index);
    assign cand_inc = r_cand + 8'd1;
    assign beyond   = ({1'b0, cand_inc} >= 9'(NUM_LEDS));
    assign cand_n   = beyond ? 8'd0 : cand_inc;
    assign rd_addr  = AW'(cand_n);
    assign ovh_ext  = {10'd0, r_ovh};
    assign net      = r_raw - ovh_ext;
    assign push_ok  = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_raw <= ovh_ext) begin
            dwell = 16'd0;
        end else if (net > {10'd0, lms_pkg::DWELL_LIMIT}) begin
            dwell = lms_pkg::DWELL_LIMIT;
        end else begin
            dwell = net[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.mode)
                        lms_pkg::MODE_LATCH:   n_state = S_LATCH;
                        lms_pkg::MODE_ADVANCE: n_state = S_STEP;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_LATCH: begin
                if (r_cnt == AW'(NUM_LEDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                n_state = (beyond && !r_wrap) ? S_PUSH : S_CHK;
            end
            S_CHK: begin
                n_state = (r_lat_v && (r_lat_q != 8'd0)) ? S_MUL1 : S_STEP;
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DWELL;
            S_DWELL: n_state = S_PUSH;
            S_PUSH: begin
                if (push_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // working store
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.mode == lms_pkg::MODE_WRITE) && wr_ok) begin
            wrk_mem[wr_addr] <= i_in.brightness;
        end
        if (r_state == S_LATCH) begin
            r_wrk_q <= wrk_mem[r_cnt];
        end
    end

    // latched store
    always_ff @(posedge i_clk) begin
        if (r_cp_vld) begin
            lat_mem[r_cp_addr] <= r_cp_wv ? r_wrk_q : 8'd0;
        end
        if (r_state == S_STEP) begin
            r_lat_q <= lat_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w_valid   <= '0;
            r_l_valid   <= '0;
            r_scale     <= lms_pkg::SCALE_RESET;
            r_ovh       <= lms_pkg::OVERHEAD_RST;
            r_scan      <= lms_pkg::NO_POSITION;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lms_pkg::CFG_TICK_SCALE:    r_scale <= i_cfg_data[9:0];
                    lms_pkg::CFG_TICK_OVERHEAD: r_ovh   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (accept && (i_in.mode == lms_pkg::MODE_WRITE) && wr_ok) begin
                r_w_valid[wr_addr] <= 1'b1;
            end else if (accept && (i_in.mode == lms_pkg::MODE_CLEAR)) begin
                r_w_valid <= '0;
            end

            r_cp_vld <= (r_state == S_LATCH);
            if (r_cp_vld) begin
                r_l_valid[r_cp_addr] <= 1'b1;
            end

            if ((r_state == S_STEP) && beyond && !r_wrap) begin
                r_scan <= lms_pkg::NO_POSITION;
            end else if (r_state == S_DWELL) begin
                r_scan <= r_cand;
            end

            if ((r_state == S_PUSH) && push_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand <= r_scan;
            r_wrap <= i_in.wrap_around;
            r_cnt  <= '0;
        end
        if (r_state == S_LATCH) begin
            r_cnt     <= r_cnt + AW'(1);
            r_cp_addr <= r_cnt;
            r_cp_wv   <= r_w_valid[r_cnt];
        end
        if (r_state == S_STEP) begin
            r_cand  <= cand_n;
            r_lat_v <= r_l_valid[rd_addr];
            if (beyond) begin
                r_wrap <= 1'b0;
            end
            if (beyond && !r_wrap) begin
                r_res.status     <= lms_pkg::STATUS_DONE;
                r_res.lit_index  <= 4'd0;
                r_res.wait_ticks <= lms_pkg::FRAME_WAIT;
            end
        end
        if (r_state == S_CHK) begin
            r_level <= r_lat_q;
        end
        if (r_state == S_MUL1) begin
            r_sq <= {8'd0, r_level} * {8'd0, r_level};
        end
        if (r_state == S_MUL2) begin
            r_raw <= {16'd0, r_scale} * {10'd0, r_sq};
        end
        if (r_state == S_DWELL) begin
            r_res.status     <= lms_pkg::STATUS_LIT;
            r_res.lit_index  <= r_cand[3:0];
            r_res.wait_ticks <= dwell;
        end
        if ((r_state == S_PUSH) && push_ok) begin
            r_out <= r_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan == lms_pkg::NO_POSITION) || ({1'b0, r_scan} < 9'(NUM_LEDS)))
        else $error("scan position out of range");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == lms_pkg::STATUS_DONE)) |->
        ((o_out.lit_index == 4'd0) && (o_out.wait_ticks == lms_pkg::FRAME_WAIT)))
        else $error("end of frame result malformed");

    a_dwell_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == lms_pkg::STATUS_LIT)) |->
        (o_out.wait_ticks <= lms_pkg::DWELL_LIMIT))
        else $error("dwell above limit");

    a_adv_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.mode == lms_pkg::MODE_ADVANCE)) |=> (r_state == S_STEP))
        else $error("advance did not start scan");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED scanner. Requests are driven with random
// gaps and results are drained with random back-pressure, but for a steady
// phase of the random test; every result is compared with a scan predictor
// that tracks the level stores, the scan position and the dwell settings.
// ----------------------------------------------------------------------------
module tb_top;
    import lms_pkg::*;

    localparam int LEDS          = NUM_LEDS_DEF;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int PHASES        = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_req               i_in        = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_rsp              o_out;
    logic                  o_cfg_ready;

    // predictor state
    logic [7:0]  working_lvl [LEDS];
    logic [7:0]  latched_lvl [LEDS];
    logic [7:0]  scan_pos;
    logic [9:0]  tick_scale;
    logic [15:0] tick_overhead;

    t_out_rsp    expected_scans [$];
    t_out_rsp    due_scan;
    int          n_errors     = 0;
    int          stall_cycles = 0;
    bit          steady       = 1'b0;

    led_multiplex_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_req mk_req(input logic [1:0] mode, input logic [3:0] idx,
                                       input logic [7:0] lvl, input logic wrap);
        t_in_req r;
        r.mode        = mode;
        r.led_index   = idx;
        r.brightness  = lvl;
        r.wrap_around = wrap;
        return r;
    endfunction

    function automatic logic [7:0] rand_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) return 8'd0;
        if (pick < 35) return 8'd255;
        if (pick < 40) return 8'd1;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] dwell_ticks(input logic [7:0] level);
        logic [31:0] raw;
        logic [31:0] net;
        raw = 32'(tick_scale) * 32'(level) * 32'(level);
        if (raw <= 32'(tick_overhead)) return '0;
        net = raw - 32'(tick_overhead);
        return (net > 32'(DWELL_LIMIT)) ? DWELL_LIMIT : net[15:0];
    endfunction

    task automatic reset_model();
        foreach (working_lvl[i]) working_lvl[i] = '0;
        foreach (latched_lvl[i]) latched_lvl[i] = '0;
        scan_pos      = NO_POSITION;
        tick_scale    = SCALE_RESET;
        tick_overhead = OVERHEAD_RST;
    endtask

    task automatic predict_scan(input t_in_req r);
        logic [7:0] pos;
        bit         may_wrap;
        bit         settled;
        t_out_rsp   rsp;
        case (r.mode)
            MODE_WRITE: begin
                if (int'(r.led_index) < LEDS) working_lvl[r.led_index] = r.brightness;
            end
            MODE_LATCH: begin
                latched_lvl = working_lvl;
            end
            MODE_CLEAR: begin
                foreach (working_lvl[i]) working_lvl[i] = '0;
            end
            MODE_ADVANCE: begin
                pos      = scan_pos;
                may_wrap = r.wrap_around;
                settled  = 1'b0;
                rsp      = '0;
                while (!settled) begin
                    pos = pos + 8'd1;
                    if (int'(pos) >= LEDS) begin
                        if (may_wrap) begin
                            pos      = '0;
                            may_wrap = 1'b0;
                        end else begin
                            rsp.status     = STATUS_DONE;
                            rsp.lit_index  = '0;
                            rsp.wait_ticks = FRAME_WAIT;
                            settled        = 1'b1;
                        end
                    end
                    if (!settled && latched_lvl[pos[3:0]] != 8'd0) begin
                        rsp.status     = STATUS_LIT;
                        rsp.lit_index  = pos[3:0];
                        rsp.wait_ticks = dwell_ticks(latched_lvl[pos[3:0]]);
                        settled        = 1'b1;
                    end
                end
                scan_pos = (rsp.status == STATUS_DONE) ? NO_POSITION : pos;
                expected_scans.push_back(rsp);
            end
        endcase
    endtask

    task automatic send_req(input t_in_req r);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predict_scan(r);
    endtask

    // all results in, then room for a latch sweep or a long advance
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TICK_SCALE) tick_scale = data[9:0];
        else tick_overhead = data;
        @(posedge i_clk);
    endtask

    task automatic set_dwell(input logic [9:0] scale, input logic [15:0] overhead);
        wait_idle();
        write_reg(CFG_TICK_SCALE, {6'd0, scale});
        write_reg(CFG_TICK_OVERHEAD, overhead);
    endtask

    task automatic test_empty_frame();
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_ADVANCE, 4'hF, 8'hFF, 1'b1));
        send_req(mk_req(MODE_LATCH, 4'hF, 8'hFF, 1'b1));
        send_req(mk_req(MODE_CLEAR, 4'hA, 8'h55, 1'b0));
    endtask

    task automatic test_levels_and_wrap();
        send_req(mk_req(MODE_WRITE, 4'd0, 8'd255, 1'b1));
        send_req(mk_req(MODE_WRITE, 4'd15, 8'd1, 1'b0));
        send_req(mk_req(MODE_WRITE, 4'd7, 8'd16, 1'b0));
        send_req(mk_req(MODE_WRITE, 4'd3, 8'd0, 1'b1));
        send_req(mk_req(MODE_LATCH, 4'd5, 8'hAA, 1'b0));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_ADVANCE, 4'hF, 8'hFF, 1'b1));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_CLEAR, 4'h3, 8'h0F, 1'b1));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b0));
        send_req(mk_req(MODE_LATCH, 4'hC, 8'hF0, 1'b1));
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
    endtask

    task automatic test_dwell_limits();
        send_req(mk_req(MODE_WRITE, 4'd5, 8'd200, 1'b0));
        send_req(mk_req(MODE_LATCH, 4'd0, 8'd0, 1'b0));
        set_dwell(10'd0, 16'd0);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
        set_dwell(10'd1023, 16'd0);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
        set_dwell(10'd1, 16'd65535);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
        set_dwell(10'd1023, 16'd65535);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
        set_dwell(10'd1, 16'd39999);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
        set_dwell(10'd1, 16'd40000);
        send_req(mk_req(MODE_ADVANCE, 4'd0, 8'd0, 1'b1));
    endtask

    task automatic test_random_scan();
        int      sent;
        int      n_wr;
        int      n_adv;
        t_in_req noise;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_dwell(SCALE_RESET, OVERHEAD_RST);
                1: set_dwell(10'd1023, 16'($urandom));
                2: set_dwell(10'($urandom_range(8)), 16'($urandom_range(300)));
                3: set_dwell(10'($urandom), 16'($urandom_range(5000)));
                4: set_dwell(10'($urandom), 16'd0);
                default: set_dwell(10'($urandom_range(4)), 16'($urandom));
            endcase
            steady = (phase == 3);
            sent   = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                if ($urandom_range(9) == 0) begin
                    noise = t_in_req'($urandom);
                    send_req(noise);
                    sent++;
                end else begin
                    if ($urandom_range(9) == 0) begin
                        send_req(mk_req(MODE_CLEAR, 4'($urandom), 8'($urandom), 1'($urandom)));
                        sent++;
                    end
                    n_wr = $urandom_range(6, 1);
                    repeat (n_wr) begin
                        send_req(mk_req(MODE_WRITE, 4'($urandom), rand_level(), 1'($urandom)));
                    end
                    sent += n_wr;
                    if ($urandom_range(9) != 0) begin
                        send_req(mk_req(MODE_LATCH, 4'($urandom), 8'($urandom), 1'($urandom)));
                        sent++;
                    end
                    n_adv = $urandom_range(20, 1);
                    repeat (n_adv) begin
                        send_req(mk_req(MODE_ADVANCE, 4'($urandom), 8'($urandom),
                                        $urandom_range(3) == 0));
                    end
                    sent += n_adv;
                end
            end
        end
        steady = 1'b0;
    endtask

    // result side: compare, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_scans.size() == 0) begin
                $error("unexpected result: status %0d lit_index %0d wait_ticks %0d",
                       o_out.status, o_out.lit_index, o_out.wait_ticks);
                n_errors++;
            end else begin
                due_scan = expected_scans.pop_front();
                if (o_out.status !== due_scan.status) begin
                    $error("status: expected %0d, actual %0d", due_scan.status, o_out.status);
                    n_errors++;
                end
                if (o_out.lit_index !== due_scan.lit_index) begin
                    $error("lit_index: expected %0d, actual %0d",
                           due_scan.lit_index, o_out.lit_index);
                    n_errors++;
                end
                if (o_out.wait_ticks !== due_scan.wait_ticks) begin
                    $error("wait_ticks: expected %0d, actual %0d",
                           due_scan.wait_ticks, o_out.wait_ticks);
                    n_errors++;
                end
            end
        end
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_frame();
        test_levels_and_wrap();
        test_dwell_limits();
        test_random_scan();
        wait_idle();
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[led_multiplex_scanner.f]
rtl/lms_pkg.sv
rtl/led_multiplex_scanner.sv
dv/tb_top.sv
